@@ src/iatirq_pkg.sv @@
// ----------------------------------------------------------------------------
// iatirq_pkg
// Shared types and constants for the two-timer interrupt adapter.
// ----------------------------------------------------------------------------
package iatirq_pkg;

	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [3:0] REG_TA_LO = 4'h4;
	localparam logic [3:0] REG_TA_HI = 4'h5;
	localparam logic [3:0] REG_TB_LO = 4'h6;
	localparam logic [3:0] REG_TB_HI = 4'h7;
	localparam logic [3:0] REG_ICR   = 4'hd;
	localparam logic [3:0] REG_CRA   = 4'he;
	localparam logic [3:0] REG_CRB   = 4'hf;

	localparam int unsigned CTRL_START_BIT   = 0;
	localparam int unsigned CTRL_ONESHOT_BIT = 3;
	localparam int unsigned CTRL_LOAD_BIT    = 4;
	localparam int unsigned ICR_SET_BIT      = 7;
	localparam logic [6:0]  MASK_BITS        = 7'h7f;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_CNT_A_LO,
		RD_CNT_A_HI,
		RD_CNT_B_LO,
		RD_CNT_B_HI,
		RD_STATUS,
		RD_CTRL_A,
		RD_CTRL_B
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_LATCH_A_LO,
		WR_LATCH_A_HI,
		WR_LATCH_B_LO,
		WR_LATCH_B_HI,
		WR_MASK,
		WR_CTRL_A,
		WR_CTRL_B
	} wr_sel_t;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_CONT    = 2'd1,
		MODE_ONCE    = 2'd2
	} mode_t;

	typedef struct packed {
		rd_sel_t    rd_sel;
		wr_sel_t    wr_sel;
		logic [7:0] data;
		logic [7:0] dt;
	} cmd_t;

endpackage

@@ src/iatirq_req_if.sv @@
// ----------------------------------------------------------------------------
// iatirq_req_if
// Bus access and tick channel into the adapter.
// ----------------------------------------------------------------------------
interface iatirq_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [3:0] reg_index;
	logic [7:0] write_data;
	logic [7:0] elapsed_cycles;

	modport source (output valid, kind, reg_index, write_data, elapsed_cycles, input ready);
	modport sink (input valid, kind, reg_index, write_data, elapsed_cycles, output ready);
endinterface

@@ src/iatirq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// iatirq_rsp_if
// Result channel out of the adapter.
// ----------------------------------------------------------------------------
interface iatirq_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       irq_request;
	logic       nmi_request;
	logic       timers_active;

	modport source (output valid, read_data, irq_request, nmi_request, timers_active,
		input ready);
	modport sink (input valid, read_data, irq_request, nmi_request, timers_active,
		output ready);
endinterface

@@ src/iatirq_front.sv @@
// ----------------------------------------------------------------------------
// iatirq_front
// Accepts transactions and decodes them into register read/write selects.
// ----------------------------------------------------------------------------
module iatirq_front (
	iatirq_req_if.sink        req,
	output logic              push_valid,
	output iatirq_pkg::cmd_t  push_cmd,
	input  logic              push_ready
);

	always_comb begin
		push_cmd.rd_sel = iatirq_pkg::RD_NONE;
		push_cmd.wr_sel = iatirq_pkg::WR_NONE;
		push_cmd.data   = req.write_data;
		push_cmd.dt     = req.elapsed_cycles;
		if (req.kind == iatirq_pkg::KIND_READ) begin
			case (req.reg_index)
				iatirq_pkg::REG_TA_LO: push_cmd.rd_sel = iatirq_pkg::RD_CNT_A_LO;
				iatirq_pkg::REG_TA_HI: push_cmd.rd_sel = iatirq_pkg::RD_CNT_A_HI;
				iatirq_pkg::REG_TB_LO: push_cmd.rd_sel = iatirq_pkg::RD_CNT_B_LO;
				iatirq_pkg::REG_TB_HI: push_cmd.rd_sel = iatirq_pkg::RD_CNT_B_HI;
				iatirq_pkg::REG_ICR:   push_cmd.rd_sel = iatirq_pkg::RD_STATUS;
				iatirq_pkg::REG_CRA:   push_cmd.rd_sel = iatirq_pkg::RD_CTRL_A;
				iatirq_pkg::REG_CRB:   push_cmd.rd_sel = iatirq_pkg::RD_CTRL_B;
				default:               push_cmd.rd_sel = iatirq_pkg::RD_NONE;
			endcase
		end else if (req.kind == iatirq_pkg::KIND_WRITE) begin
			case (req.reg_index)
				iatirq_pkg::REG_TA_LO: push_cmd.wr_sel = iatirq_pkg::WR_LATCH_A_LO;
				iatirq_pkg::REG_TA_HI: push_cmd.wr_sel = iatirq_pkg::WR_LATCH_A_HI;
				iatirq_pkg::REG_TB_LO: push_cmd.wr_sel = iatirq_pkg::WR_LATCH_B_LO;
				iatirq_pkg::REG_TB_HI: push_cmd.wr_sel = iatirq_pkg::WR_LATCH_B_HI;
				iatirq_pkg::REG_ICR:   push_cmd.wr_sel = iatirq_pkg::WR_MASK;
				iatirq_pkg::REG_CRA:   push_cmd.wr_sel = iatirq_pkg::WR_CTRL_A;
				iatirq_pkg::REG_CRB:   push_cmd.wr_sel = iatirq_pkg::WR_CTRL_B;
				default:               push_cmd.wr_sel = iatirq_pkg::WR_NONE;
			endcase
		end
	end

	assign push_valid = req.valid;
	assign req.ready  = push_ready;

endmodule

@@ src/iatirq_queue.sv @@
// ----------------------------------------------------------------------------
// iatirq_queue
// Small FIFO of decoded commands between the front and back ends.
// ----------------------------------------------------------------------------
module iatirq_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  iatirq_pkg::cmd_t  push_cmd,
	output logic              push_ready,
	output logic              pop_valid,
	output iatirq_pkg::cmd_t  pop_cmd,
	input  logic              pop_ready
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	iatirq_pkg::cmd_t  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ src/iatirq_back.sv @@
// ----------------------------------------------------------------------------
// iatirq_back
// Executes commands: register access, timer advance, interrupt update.
// ----------------------------------------------------------------------------
module iatirq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              pop_valid,
	input  iatirq_pkg::cmd_t  pop_cmd,
	output logic              pop_ready,
	iatirq_rsp_if.source      rsp
);

	typedef struct packed {
		logic [15:0]       count;
		iatirq_pkg::mode_t mode;
		logic              uf;
	} tmr_t;

	function automatic tmr_t advance(logic [15:0] count, iatirq_pkg::mode_t mode,
		logic [15:0] latch, logic [7:0] dt);
		tmr_t        r;
		logic [15:0] diff;
		diff   = count - {8'd0, dt};
		r.count = count;
		r.mode  = mode;
		r.uf    = 1'b0;
		if (mode == iatirq_pkg::MODE_CONT || mode == iatirq_pkg::MODE_ONCE) begin
			if (count >= {8'd0, dt}) begin
				r.count = diff;
			end else begin
				r.uf = 1'b1;
				if (mode == iatirq_pkg::MODE_CONT) begin
					r.count = latch + diff;
				end else begin
					r.count = '0;
					r.mode  = iatirq_pkg::MODE_STOPPED;
				end
			end
		end
		return r;
	endfunction

	function automatic tmr_t control(tmr_t t, logic [7:0] v, logic [15:0] latch);
		tmr_t r;
		r = t;
		if (v[iatirq_pkg::CTRL_LOAD_BIT]) begin
			r.count = latch;
		end
		if (!v[iatirq_pkg::CTRL_START_BIT]) begin
			r.mode = iatirq_pkg::MODE_STOPPED;
		end else if (v[iatirq_pkg::CTRL_ONESHOT_BIT]) begin
			r.mode = iatirq_pkg::MODE_ONCE;
		end else begin
			r.mode = iatirq_pkg::MODE_CONT;
		end
		return r;
	endfunction

	logic [15:0]       count_a_q, count_b_q, latch_a_q, latch_b_q;
	iatirq_pkg::mode_t mode_a_q, mode_b_q;
	logic [6:0]        irq_mask_q;
	logic [7:0]        irq_status_q, ctrl_a_q, ctrl_b_q;
	logic              unit_select_q;
	logic              out_valid_q;
	logic [7:0]        read_data_q;
	logic              irq_q, nmi_q, active_q;

	logic [15:0]       latch_a_n, latch_b_n;
	tmr_t              ta, tb;
	logic [6:0]        mask_n;
	logic [7:0]        status_n, fresh;
	logic [7:0]        rd;
	logic              running;
	logic              pop;

	assign pop_ready = !out_valid_q || rsp.ready;
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		case (pop_cmd.rd_sel)
			iatirq_pkg::RD_CNT_A_LO: rd = count_a_q[7:0];
			iatirq_pkg::RD_CNT_A_HI: rd = count_a_q[15:8];
			iatirq_pkg::RD_CNT_B_LO: rd = count_b_q[7:0];
			iatirq_pkg::RD_CNT_B_HI: rd = count_b_q[15:8];
			iatirq_pkg::RD_STATUS:   rd = irq_status_q;
			iatirq_pkg::RD_CTRL_A:   rd = ctrl_a_q;
			iatirq_pkg::RD_CTRL_B:   rd = ctrl_b_q;
			default:                 rd = 8'd0;
		endcase

		latch_a_n = latch_a_q;
		latch_b_n = latch_b_q;
		case (pop_cmd.wr_sel)
			iatirq_pkg::WR_LATCH_A_LO: latch_a_n[7:0]  = pop_cmd.data;
			iatirq_pkg::WR_LATCH_A_HI: latch_a_n[15:8] = pop_cmd.data;
			iatirq_pkg::WR_LATCH_B_LO: latch_b_n[7:0]  = pop_cmd.data;
			iatirq_pkg::WR_LATCH_B_HI: latch_b_n[15:8] = pop_cmd.data;
			default: ;
		endcase

		ta = advance(count_a_q, mode_a_q, latch_a_n, pop_cmd.dt);
		tb = advance(count_b_q, mode_b_q, latch_b_n, pop_cmd.dt);
		fresh = {6'd0, tb.uf, ta.uf};

		status_n = (pop_cmd.rd_sel == iatirq_pkg::RD_STATUS) ? 8'd0 : irq_status_q;

		mask_n = irq_mask_q;
		if (pop_cmd.wr_sel == iatirq_pkg::WR_MASK) begin
			if (pop_cmd.data[iatirq_pkg::ICR_SET_BIT]) begin
				mask_n = irq_mask_q | pop_cmd.data[6:0];
			end else begin
				mask_n = irq_mask_q & (~pop_cmd.data[6:0] & iatirq_pkg::MASK_BITS);
			end
		end
		if (pop_cmd.wr_sel == iatirq_pkg::WR_CTRL_A) begin
			ta = control(ta, pop_cmd.data, latch_a_n);
		end
		if (pop_cmd.wr_sel == iatirq_pkg::WR_CTRL_B) begin
			tb = control(tb, pop_cmd.data, latch_b_n);
		end

		running = (ta.mode == iatirq_pkg::MODE_CONT) || (ta.mode == iatirq_pkg::MODE_ONCE) ||
			(tb.mode == iatirq_pkg::MODE_CONT) || (tb.mode == iatirq_pkg::MODE_ONCE);

		if ((mask_n & fresh[6:0]) != 7'd0) begin
			fresh[7] = 1'b1;
		end
		status_n = status_n | fresh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q     <= '0;
			count_b_q     <= '0;
			latch_a_q     <= '0;
			latch_b_q     <= '0;
			mode_a_q      <= iatirq_pkg::MODE_STOPPED;
			mode_b_q      <= iatirq_pkg::MODE_STOPPED;
			irq_mask_q    <= '0;
			irq_status_q  <= '0;
			ctrl_a_q      <= '0;
			ctrl_b_q      <= '0;
			unit_select_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unit_select_q <= cfg_wdata;
			end
			if (pop) begin
				count_a_q    <= ta.count;
				count_b_q    <= tb.count;
				mode_a_q     <= ta.mode;
				mode_b_q     <= tb.mode;
				latch_a_q    <= latch_a_n;
				latch_b_q    <= latch_b_n;
				irq_mask_q   <= mask_n;
				irq_status_q <= status_n;
				if (pop_cmd.wr_sel == iatirq_pkg::WR_CTRL_A) begin
					ctrl_a_q <= pop_cmd.data;
				end
				if (pop_cmd.wr_sel == iatirq_pkg::WR_CTRL_B) begin
					ctrl_b_q <= pop_cmd.data;
				end
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			read_data_q <= rd;
			irq_q       <= status_n[7] && !unit_select_q;
			nmi_q       <= status_n[7] && unit_select_q;
			active_q    <= running || status_n[7];
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_data     = read_data_q;
	assign rsp.irq_request   = irq_q;
	assign rsp.nmi_request   = nmi_q;
	assign rsp.timers_active = active_q;

endmodule

@@ src/interface_adapter_timers_irq.sv @@
// ----------------------------------------------------------------------------
// interface_adapter_timers_irq
// Two-timer interrupt adapter, 6526 style, with decoupled decode and execute.
// ----------------------------------------------------------------------------
// Each request transaction carries an optional register read or write and a
// tick count; it yields one response with the read byte and the IRQ/NMI and
// activity flags. The decode stage feeds a QUEUE_DEPTH-entry command FIFO, and
// the execute stage applies one command per cycle (one subtract/compare per
// timer), so throughput is one transaction per clock while responses are
// taken; a command passes the queue, then the response register. While a
// response waits to be taken the execute stage holds, and the queue absorbs
// up to QUEUE_DEPTH further transactions before the request channel stalls.
// unit_select (cfg_we/cfg_wdata) steers the interrupt to IRQ (0) or NMI (1).
module interface_adapter_timers_irq #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	iatirq_req_if.sink   req,
	iatirq_rsp_if.source rsp,
	input  logic         cfg_we,
	input  logic         cfg_wdata
);

	logic             push_valid;
	logic             push_ready;
	iatirq_pkg::cmd_t push_cmd;
	logic             q_valid;
	logic             q_ready;
	iatirq_pkg::cmd_t q_cmd;

	iatirq_front u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	iatirq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_cmd    (q_cmd),
		.pop_ready  (q_ready)
	);

	iatirq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pop_valid (q_valid),
		.pop_cmd   (q_cmd),
		.pop_ready (q_ready),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> q_valid)
		else $error("accepted transaction did not reach the command queue");

	a_pop_yields_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |=> rsp.valid)
		else $error("executed command produced no response");

	a_irq_nmi_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.irq_request && rsp.nmi_request))
		else $error("IRQ and NMI raised together");

	a_irq_active: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.irq_request || rsp.nmi_request)) |-> rsp.timers_active)
		else $error("interrupt pending but not reported active");
`endif

endmodule
